// ----- rtl/least_loaded_server_picker_top_macros.svh -----
// Assertion macros for the least-loaded server picker.
// Needs a clk and an active-high rst in the scope that uses them.
`ifndef LEAST_LOADED_SERVER_PICKER_TOP_MACROS_SVH
`define LEAST_LOADED_SERVER_PICKER_TOP_MACROS_SVH

// same-cycle implication
`define LLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lls_pkg.sv -----
// Shared constants and types for the least-loaded server picker.
// No dependencies.
package lls_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int LOAD_BITS   = 32;
  localparam int TIME_W      = 16;
  localparam int CFG_W       = 5;
  localparam int SRV_W       = 5;
  localparam int IDX_W       = $clog2(MAX_SERVERS);
  localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
  localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // command field of an input beat
  typedef enum logic {
    CMD_JOB    = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  // control from the sequencer to the load store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             clear;
  } mem_req_t;

endpackage

// ----- rtl/least_loaded_server_picker_top.sv -----
// Least-loaded server picker. While the batch is still filling its servers,
// a job does one read and one write-back of the load store. Once every
// server has a job, it runs a scan over n entries, n being the effective
// server count, that reads one load per cycle from the store before the
// saturating update. A finish clears all loads, after the same scan once
// every server has a job. The input is taken only when the previous beat
// is done; a finished result waits in an output register. The configuration
// write is always ready and must only be used while the block is idle.
// Depends on lls_pkg, lls_load_mem and lls_ctrl.
module least_loaded_server_picker_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lls_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic [lls_pkg::TIME_W-1:0]  service_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lls_pkg::SRV_W-1:0]   next_server
);

  logic [lls_pkg::CFG_W-1:0]     num_servers;
  logic [lls_pkg::CNT_W-1:0]     n_active;
  lls_pkg::mem_req_t             mem_req;
  logic [lls_pkg::LOAD_BITS-1:0] wr_data;
  logic [lls_pkg::LOAD_BITS-1:0] rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_servers <= lls_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      num_servers <= cfg_data;
    end
  end

  // zero acts as one, anything above the array size as the array size
  always_comb begin
    if (num_servers == '0) begin
      n_active = lls_pkg::CNT_W'(1);
    end else if (lls_pkg::CMP_W'(num_servers) > lls_pkg::CMP_W'(lls_pkg::MAX_SERVERS)) begin
      n_active = lls_pkg::CNT_W'(lls_pkg::MAX_SERVERS);
    end else begin
      n_active = lls_pkg::CNT_W'(num_servers);
    end
  end

  lls_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .n_active     (n_active),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .service_time (service_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_server  (next_server),
    .mem_req      (mem_req),
    .wr_data      (wr_data),
    .rd_data      (rd_data)
  );

  lls_load_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

// ----- rtl/lls_load_mem.sv -----
// Per-server load store: synchronous RAM, one read and one write port.
// Valid bits make unwritten or cleared entries read as zero. Uses lls_pkg.
module lls_load_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  lls_pkg::mem_req_t             req,
  input  logic [lls_pkg::LOAD_BITS-1:0] wr_data,
  output logic [lls_pkg::LOAD_BITS-1:0] rd_data
);

  logic [lls_pkg::LOAD_BITS-1:0]   mem [lls_pkg::MAX_SERVERS];
  logic [lls_pkg::MAX_SERVERS-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  // clear wipes the whole batch: every valid bit drops together
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

endmodule

// ----- rtl/lls_ctrl.sv -----
// Sequencer: fill phase, min-scan over the load store, saturating update,
// finish handling and result register. Uses lls_pkg and the assertion macros.
`include "least_loaded_server_picker_top_macros.svh"

module lls_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lls_pkg::CNT_W-1:0]     n_active,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [lls_pkg::TIME_W-1:0]    service_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lls_pkg::SRV_W-1:0]     next_server,
  output lls_pkg::mem_req_t             mem_req,
  output logic [lls_pkg::LOAD_BITS-1:0] wr_data,
  input  logic [lls_pkg::LOAD_BITS-1:0] rd_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILL = 5'b00010,
    S_SCAN = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                          state, state_next;
  logic                            cmd;
  logic [lls_pkg::TIME_W-1:0]      t;
  logic [lls_pkg::CNT_W-1:0]       jobs_seen;
  logic [lls_pkg::IDX_W-1:0]       k;
  logic [lls_pkg::IDX_W-1:0]       best_idx, best_idx_next;
  logic [lls_pkg::LOAD_BITS-1:0]   best_load, best_load_next;
  logic [lls_pkg::CNT_W-1:0]       res;
  logic [lls_pkg::IDX_W-1:0]       last_idx;
  logic                            scan_last;
  logic                            filling;
  logic                            accept;

  function automatic logic [lls_pkg::LOAD_BITS-1:0] sat_add(
    input logic [lls_pkg::LOAD_BITS-1:0] cur,
    input logic [lls_pkg::TIME_W-1:0]    inc
  );
    logic [lls_pkg::LOAD_BITS:0] sum;
    sum = {1'b0, cur} + (lls_pkg::LOAD_BITS+1)'(inc);
    return sum[lls_pkg::LOAD_BITS] ? '1 : sum[lls_pkg::LOAD_BITS-1:0];
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign filling   = (jobs_seen < n_active);
  assign last_idx  = lls_pkg::IDX_W'(n_active - lls_pkg::CNT_W'(1));
  assign scan_last = (k == last_idx);

  // running minimum; strict less keeps the lowest number on a tie
  always_comb begin
    best_idx_next  = best_idx;
    best_load_next = best_load;
    if (k == '0 || rd_data < best_load) begin
      best_idx_next  = k;
      best_load_next = rd_data;
    end
  end

  always_comb begin
    state_next      = state;
    mem_req         = '0;
    wr_data         = sat_add(rd_data, t);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (filling) begin
            if (command == lls_pkg::CMD_JOB) begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = jobs_seen[lls_pkg::IDX_W-1:0];
              state_next      = S_FILL;
            end else begin
              mem_req.clear = 1'b1;
              state_next    = S_OUT;
            end
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = '0;
            state_next      = S_SCAN;
          end
        end
      end
      S_FILL: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = jobs_seen[lls_pkg::IDX_W-1:0];
        state_next      = S_IDLE;
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_UPD;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = k + lls_pkg::IDX_W'(1);
        end
      end
      S_UPD: begin
        if (cmd == lls_pkg::CMD_JOB) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = best_idx;
          wr_data         = sat_add(best_load, t);
          state_next      = S_IDLE;
        end else begin
          mem_req.clear = 1'b1;
          state_next    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      jobs_seen <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mem_req.clear) begin
        jobs_seen <= '0;
      end else if (mem_req.wr_en && jobs_seen < lls_pkg::CNT_W'(lls_pkg::MAX_SERVERS)) begin
        jobs_seen <= jobs_seen + lls_pkg::CNT_W'(1);
      end
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= command;
      t   <= service_time;
      k   <= '0;
      res <= jobs_seen + lls_pkg::CNT_W'(1);
    end
    if (state == S_SCAN) begin
      best_idx  <= best_idx_next;
      best_load <= best_load_next;
      k         <= k + lls_pkg::IDX_W'(1);
    end
    if (state == S_UPD) begin
      res <= lls_pkg::CNT_W'(best_idx) + lls_pkg::CNT_W'(1);
    end
    if (state == S_OUT && (!out_valid || out_ready)) begin
      next_server <= lls_pkg::SRV_W'(res);
    end
  end

  `LLS_ASSERT_NOW(a_no_rw_overlap, mem_req.rd_en, !mem_req.wr_en, "read and write in one cycle")
  `LLS_ASSERT_NEXT(a_clear_resets_count, mem_req.clear, jobs_seen == '0, "count not cleared")
  `LLS_ASSERT_NOW(a_scan_in_range, state == S_SCAN, lls_pkg::CNT_W'(k) < n_active, "scan past count")
  `LLS_ASSERT_NOW(a_fill_after_read, state == S_FILL, $past(mem_req.rd_en), "fill without read")

endmodule
